// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/itoar_pkg.sv
// shared constants, command and status types for the radix converter
`default_nettype none

package itoar_pkg;

   // field widths of the channel words
   localparam int VALUE_BITS = 64;
   localparam int KIND_BITS = 3;
   localparam int CHAR_BITS = 7;
   localparam int DEFAULT_VALUE_WIDTH = 64;

   // format codes
   localparam logic [KIND_BITS-1:0] KIND_UDEC = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_OCT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_HEXL = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_HEXU = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_SDEC = 3'd4;

   // ascii offsets
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0] HEX_LOWER_OFFSET = 7'd87;
   localparam logic [CHAR_BITS-1:0] HEX_UPPER_OFFSET = 7'd55;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

   // binary bits folded into the bcd register per conversion cycle
   localparam int DABBLE_STEP = 4;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic conv;
      logic skip;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic slot_free;
      logic is_dec;
      logic is_neg;
      logic conv_done;
      logic digit_zero;
      logic cnt_zero;
   } status_type;

   // decimal digits of 2**w - 1 (1233/4096 approximates log10 of two)
   function automatic int dec_digits(input int w);
      return (w * 1233) / 4096 + 1;
   endfunction

   function automatic int oct_digits(input int w);
      return (w + 2) / 3;
   endfunction

   function automatic int hex_digits(input int w);
      return (w + 3) / 4;
   endfunction

   // double dabble correction of one bcd digit
   function automatic logic [3:0] dabble_fix(input logic [3:0] d);
      return (d >= 4'd5) ? (d + 4'd3) : d;
   endfunction

endpackage

`default_nettype wire

// File: rtl/itoar_if.sv
// request and response channel interfaces
`default_nettype none

interface itoar_req_if;
   logic                            valid;
   logic                            ready;
   logic [itoar_pkg::VALUE_BITS-1:0] value;
   logic [itoar_pkg::KIND_BITS-1:0]  kind;

   modport source (output valid, output value, output kind, input ready);
   modport sink (input valid, input value, input kind, output ready);
endinterface

interface itoar_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [itoar_pkg::CHAR_BITS-1:0] character;
   logic                           last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/itoar_ctrl.sv
// controller state machine: accept, convert, skip leading zeros, emit minus sign and digits
`default_nettype none

module itoar_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output itoar_pkg::cmd_type    cmd,
   input  itoar_pkg::status_type status
);
   import itoar_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (!status.is_dec) begin
               state_in = ST_SKIP;
            end else begin
               cmd.conv = 1'b1;
               if (status.conv_done) begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            if (status.digit_zero && !status.cnt_zero) begin
               cmd.skip = 1'b1;
            end else if (status.is_neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (status.slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_digit = 1'b1;
               if (status.cnt_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/itoar_dp.sv
// datapath: magnitude load, double dabble, digit select and output register
`default_nettype none

module itoar_dp #(
   parameter int VALUE_WIDTH = itoar_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [itoar_pkg::VALUE_BITS-1:0] req_value,
   input  logic [itoar_pkg::KIND_BITS-1:0]  req_kind,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [itoar_pkg::CHAR_BITS-1:0]  rsp_character,
   output logic                            rsp_last,
   input  itoar_pkg::cmd_type              cmd,
   output itoar_pkg::status_type           status
);
   import itoar_pkg::*;

   localparam int PAD_W = ((VALUE_WIDTH + 3) / 4) * 4;
   localparam int NDEC = dec_digits(VALUE_WIDTH);
   localparam int NOCT = oct_digits(VALUE_WIDTH);
   localparam int NHEX = hex_digits(VALUE_WIDTH);
   localparam int NDIG = (NDEC > NOCT) ? NDEC : NOCT;
   localparam int DIG_W = NDIG * 4;
   localparam int CNT_W = $clog2(NDIG);
   localparam int ITER = PAD_W / DABBLE_STEP;
   localparam int ITER_W = $clog2(ITER);

   localparam logic [CNT_W-1:0] DEC_TOP = CNT_W'(NDEC - 1);
   localparam logic [CNT_W-1:0] OCT_TOP = CNT_W'(NOCT - 1);
   localparam logic [CNT_W-1:0] HEX_TOP = CNT_W'(NHEX - 1);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER - 1);

   localparam logic [1:0] MODE_DEC = 2'd0;
   localparam logic [1:0] MODE_OCT = 2'd1;
   localparam logic [1:0] MODE_HEXL = 2'd2;
   localparam logic [1:0] MODE_HEXU = 2'd3;

   logic [PAD_W-1:0]     bin_ff, bin_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0] rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   load_neg;
   logic [1:0]             load_mode;
   logic [DIG_W-1:0]       bcd_step;
   logic [PAD_W-1:0]       bin_step;
   logic [3:0]             digit_nib;
   logic [CHAR_BITS-1:0]   hex_off;
   logic [CHAR_BITS-1:0]   digit_char;

   // format decode and two's-complement magnitude at load
   always_comb begin
      raw = req_value[VALUE_WIDTH-1:0];
      load_neg = (req_kind == KIND_SDEC) && raw[VALUE_WIDTH-1];
      mag = load_neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
      case (req_kind)
         KIND_OCT:  load_mode = MODE_OCT;
         KIND_HEXL: load_mode = MODE_HEXL;
         KIND_HEXU: load_mode = MODE_HEXU;
         default:   load_mode = MODE_DEC;
      endcase
   end

   // one conversion cycle: four shift-and-correct steps of double dabble
   always_comb begin
      bcd_step = dig_ff;
      bin_step = bin_ff;
      for (int s = 0; s < DABBLE_STEP; s++) begin
         for (int k = 0; k < NDIG; k++) begin
            bcd_step[k*4 +: 4] = dabble_fix(bcd_step[k*4 +: 4]);
         end
         bcd_step = {bcd_step[DIG_W-2:0], bin_step[PAD_W-1]};
         bin_step = {bin_step[PAD_W-2:0], 1'b0};
      end
   end

   // digit at the current position and its ascii code
   always_comb begin
      if (mode_ff == MODE_OCT) begin
         digit_nib = {1'b0, dig_ff[cnt_ff*3 +: 3]};
      end else begin
         digit_nib = dig_ff[cnt_ff*4 +: 4];
      end
      hex_off = (mode_ff == MODE_HEXU) ? HEX_UPPER_OFFSET : HEX_LOWER_OFFSET;
      if (digit_nib > 4'd9) begin
         digit_char = CHAR_BITS'(digit_nib) + hex_off;
      end else begin
         digit_char = CHAR_BITS'(digit_nib) + CHAR_ZERO;
      end
   end

   // next values of the working registers
   always_comb begin
      bin_in = bin_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      iter_in = iter_ff;
      mode_in = mode_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         bin_in = PAD_W'(mag);
         mode_in = load_mode;
         neg_in = load_neg;
         iter_in = '0;
         case (load_mode)
            MODE_OCT: begin
               dig_in = DIG_W'(raw);
               cnt_in = OCT_TOP;
            end
            MODE_HEXL, MODE_HEXU: begin
               dig_in = DIG_W'(raw);
               cnt_in = HEX_TOP;
            end
            default: begin
               dig_in = '0;
               cnt_in = DEC_TOP;
            end
         endcase
      end else if (cmd.conv) begin
         dig_in = bcd_step;
         bin_in = bin_step;
         iter_in = iter_ff + 1'b1;
      end else if (cmd.skip || (cmd.emit_digit && (cnt_ff != '0))) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = CHAR_MINUS;
         rsp_last_in = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = digit_char;
         rsp_last_in = (cnt_ff == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         iter_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         iter_ff <= iter_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      dig_ff <= dig_in;
      mode_ff <= mode_in;
      neg_ff <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // status back to the controller
   always_comb begin
      status.slot_free = !rsp_valid_ff || rsp_ready;
      status.is_dec = (mode_ff == MODE_DEC);
      status.is_neg = neg_ff;
      status.conv_done = (iter_ff == ITER_LAST);
      status.digit_zero = (digit_nib == 4'd0);
      status.cnt_zero = (cnt_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_radix.sv
// top level of the integer to ascii radix converter
//
//   channel   dir  word                       accepted when
//   req_chan  in   value[63:0], kind[2:0]     valid && ready
//   rsp_chan  out  character[6:0], last       valid && ready
//
// one value at a time: request ready only in the idle state; after the accept a decimal value
// runs through the double dabble and other formats through a decode state, then leading zero
// digits are skipped (the last digit is always kept), a minus sign is sent for a negative signed
// value, and the digits are sent; the sign and each digit wait for a free output slot
// synchronous active-high reset clears the controller and the output valid
// a stalled response holds its character and keeps the controller from sending the next one;
// the next value is taken while the last character still waits in the output register
`default_nettype none

module integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = itoar_pkg::DEFAULT_VALUE_WIDTH
) (
   input logic         clock,
   input logic         reset,
   itoar_req_if.sink   req_chan,
   itoar_rsp_if.source rsp_chan
);
   import itoar_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   itoar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   itoar_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_chan.value),
      .req_kind      (req_chan.kind),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_character (rsp_chan.character),
      .rsp_last      (rsp_chan.last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

// File: rtl/itoar_checker.sv
// port-level checks of the radix converter and their bind
`default_nettype none

`include "assert_macros.svh"

module itoar_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [itoar_pkg::CHAR_BITS-1:0]  rsp_character,
   input logic                            rsp_last
);
   import itoar_pkg::*;

   // a stalled response word keeps its valid and payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_character) && $stable(rsp_last)), "response word changed while stalled")

   // an accepted value closes the request side on the next cycle
   `ASSERT_CLK(a_req_closes, clock, reset, (req_valid && req_ready) |=> !req_ready, "request side stayed open after accept")

   // no new value is taken while a non-final character is pending
   `ASSERT_CLK(a_busy_text, clock, reset, (rsp_valid && !rsp_last) |-> !req_ready, "request ready in the middle of a text")

   // only digits, hex letters and the minus sign appear
   `ASSERT_CLK(a_char_legal, clock, reset, rsp_valid |-> ((rsp_character >= 7'd48 && rsp_character <= 7'd57) || (rsp_character >= 7'd97 && rsp_character <= 7'd102) || (rsp_character >= 7'd65 && rsp_character <= 7'd70) || (rsp_character == CHAR_MINUS)), "illegal character")

   // reset empties the output register
   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind integer_to_ascii_radix itoar_checker u_itoar_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_character (rsp_chan.character),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire
